[rtl/core/rdsgta_pkg.sv]
// ----------------------------------------------------------------------------
// rdsgta_pkg
// Payload types and fixed constants for the RDS group text assembler.
// ----------------------------------------------------------------------------
package rdsgta_pkg;

  localparam int NAME_LEN  = 8;
  localparam int TEXT_ROWS = 16;
  localparam int ROW_BYTES = 4;

  localparam logic [4:0]  GRP_0A     = 5'h00;
  localparam logic [4:0]  GRP_2A     = 5'h04;
  localparam int          TEXT_B_BIT = 4;
  localparam logic [7:0]  CR_CODE    = 8'h0D;
  localparam logic [3:0]  NAME_FULL  = 4'hF;
  localparam logic [15:0] TEXT_FULL  = 16'hFFFF;
  localparam logic [6:0]  TEXT_BASE  = 7'd8;
  localparam logic [6:0]  TEXT_END   = 7'd72;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_NAME = 2'd1;
  localparam logic [1:0] SRC_TEXT = 2'd2;

  typedef struct packed {
    logic        kind;
    logic        sync;
    logic [15:0] block_a;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic [6:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [15:0] pi_code;
    logic        sync_seen;
    logic [3:0]  name_flags;
    logic [15:0] text_flags;
    logic        complete;
    logic [7:0]  read_byte;
  } out_t;

endpackage

[rtl/core/rds_group_text_assembler_core.sv]
// ----------------------------------------------------------------------------
// rds_group_text_assembler_core
// Assembles programme-service name and radiotext from RDS groups 0A and 2A,
// tracks segment flags and serves single-byte reads of the stored text.
// ----------------------------------------------------------------------------
//  channel   signals                         role
//  in        in_valid / in_ready / in_data   group or read request
//  out       out_valid / out_ready / out_data  one result per transaction
//
//  One transaction per cycle; the result appears the cycle after acceptance.
//  All state updates and the text RAM read happen at the accepting edge.
//  in_ready drops only while a result is held and out_ready is low.
//  Synchronous reset clears PI, name bytes, flags and the text row valids;
//  no clearing pass is needed.
// ----------------------------------------------------------------------------
module rds_group_text_assembler_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rdsgta_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rdsgta_pkg::out_t  out_data
);

  logic                acc;
  logic                grp_ok;
  logic                is_0a;
  logic                is_2a;
  logic [1:0]          name_seg;
  logic [3:0]          text_seg;
  logic [3:0][7:0]     row_wr;
  logic                cr_hit;
  logic [6:0]          txt_off;
  logic [3:0]          rd_row;

  logic [15:0]         pi_r, pi_nxt;
  logic [3:0]          name_seen_r, name_seen_nxt;
  logic [15:0]         text_seen_r, text_seen_nxt;
  logic [7:0]          name_r [rdsgta_pkg::NAME_LEN];
  logic [rdsgta_pkg::TEXT_ROWS-1:0] row_vld_r;
  logic [3:0][7:0]     text_mem [rdsgta_pkg::TEXT_ROWS];

  logic                out_valid_r;
  logic                sync_r;
  logic [1:0]          src_r, src_nxt;
  logic [7:0]          name_byte_r;
  logic [3:0][7:0]     rd_row_r;
  logic [1:0]          lane_r;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  assign grp_ok   = !in_data.kind && in_data.sync;
  assign is_0a    = grp_ok && (in_data.block_b[15:11] == rdsgta_pkg::GRP_0A);
  assign is_2a    = grp_ok && (in_data.block_b[15:11] == rdsgta_pkg::GRP_2A)
                    && !in_data.block_b[rdsgta_pkg::TEXT_B_BIT];
  assign name_seg = in_data.block_b[1:0];
  assign text_seg = in_data.block_b[3:0];
  assign txt_off  = in_data.read_index - rdsgta_pkg::TEXT_BASE;
  assign rd_row   = txt_off[5:2];

  always_comb begin
    row_wr[0] = in_data.block_c[15:8];
    row_wr[1] = in_data.block_c[7:0];
    row_wr[2] = in_data.block_d[15:8];
    row_wr[3] = in_data.block_d[7:0];
    cr_hit    = 1'b0;
    for (int i = 0; i < rdsgta_pkg::ROW_BYTES; i++) begin
      if (row_wr[i] == rdsgta_pkg::CR_CODE) begin
        row_wr[i] = 8'h00;
        cr_hit    = 1'b1;
      end
    end
  end

  always_comb begin
    pi_nxt        = grp_ok ? in_data.block_a : pi_r;
    name_seen_nxt = name_seen_r;
    text_seen_nxt = text_seen_r;
    if (is_0a) begin
      name_seen_nxt = name_seen_r | (4'b0001 << name_seg);
    end
    if (is_2a) begin
      text_seen_nxt = (cr_hit ? rdsgta_pkg::TEXT_FULL : text_seen_r)
                      | (16'h0001 << text_seg);
    end
  end

  always_comb begin
    src_nxt = rdsgta_pkg::SRC_NONE;
    if (in_data.kind) begin
      if (in_data.read_index < rdsgta_pkg::TEXT_BASE) begin
        src_nxt = rdsgta_pkg::SRC_NAME;
      end else if (in_data.read_index < rdsgta_pkg::TEXT_END && row_vld_r[rd_row]) begin
        src_nxt = rdsgta_pkg::SRC_TEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pi_r        <= '0;
      name_seen_r <= '0;
      text_seen_r <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      src_r       <= rdsgta_pkg::SRC_NONE;
      for (int i = 0; i < rdsgta_pkg::NAME_LEN; i++) begin
        name_r[i] <= '0;
      end
    end else begin
      if (acc) begin
        out_valid_r <= 1'b1;
        src_r       <= src_nxt;
        pi_r        <= pi_nxt;
        name_seen_r <= name_seen_nxt;
        text_seen_r <= text_seen_nxt;
        if (is_0a) begin
          name_r[{name_seg, 1'b0}] <= in_data.block_d[15:8];
          name_r[{name_seg, 1'b1}] <= in_data.block_d[7:0];
        end
        if (is_2a) begin
          row_vld_r[text_seg] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // text RAM: one row write, one row read, read data registered
  always_ff @(posedge clk) begin
    if (acc && is_2a) begin
      text_mem[text_seg] <= row_wr;
    end
    if (acc) begin
      rd_row_r    <= text_mem[rd_row];
      lane_r      <= txt_off[1:0];
      name_byte_r <= name_r[in_data.read_index[2:0]];
      sync_r      <= in_data.sync;
    end
  end

  always_comb begin
    out_data.pi_code    = pi_r;
    out_data.sync_seen  = sync_r;
    out_data.name_flags = name_seen_r;
    out_data.text_flags = text_seen_r;
    out_data.complete   = (name_seen_r == rdsgta_pkg::NAME_FULL)
                          && (text_seen_r == rdsgta_pkg::TEXT_FULL);
    unique case (src_r)
      rdsgta_pkg::SRC_NAME: out_data.read_byte = name_byte_r;
      rdsgta_pkg::SRC_TEXT: out_data.read_byte = rd_row_r[lane_r];
      default:              out_data.read_byte = 8'h00;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/rdsgta_checker.sv]
// ----------------------------------------------------------------------------
// rdsgta_checker
// Port-level checks for the RDS group text assembler, bound to rds_group_text_assembler_core.
// ----------------------------------------------------------------------------
module rdsgta_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input rdsgta_pkg::in_t  in_data,
  input logic             out_valid,
  input logic             out_ready,
  input rdsgta_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.complete ==
      ((out_data.name_flags == rdsgta_pkg::NAME_FULL) &&
       (out_data.text_flags == rdsgta_pkg::TEXT_FULL))))
    else $error("complete disagrees with flags");

  a_flags_grow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n) |->
      ((($past(out_data.text_flags) & ~out_data.text_flags) == 16'h0000) &&
       (($past(out_data.name_flags) & ~out_data.name_flags) == 4'h0)))
    else $error("segment flag cleared");

  a_unsync: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.kind && !in_data.sync |=>
      out_valid && !out_data.sync_seen && (out_data.read_byte == 8'h00))
    else $error("unsynchronised group result wrong");

endmodule

bind rds_group_text_assembler_core rdsgta_checker u_rdsgta_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
